[rtl/rmmn_pkg.sv]
// package for the row min-max normaliser: beat types, controller states,
// command and status bundles between controller and datapath
// no dependencies
`default_nettype none

package rmmn_pkg;

    // row buffer depth and derived widths
    localparam int MAX_ROW_LEN = 64;
    localparam int ADDR_W      = $clog2(MAX_ROW_LEN);
    localparam int CNT_W       = ADDR_W + 1;

    // quotient bits produced after the integer bit
    localparam int DIV_STEPS   = 15;
    localparam int STEP_W      = $clog2(DIV_STEPS + 1);

    // input beat
    typedef struct packed {
        logic signed [15:0] score_value;
        logic               row_end;
    } t_in_item;

    // result beat
    typedef struct packed {
        logic [15:0] scaled_value;
        logic        zero_range;
        logic        last_of_row;
    } t_out_item;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_READ,
        ST_LOAD,
        ST_DIV,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic              store;
        logic              prep;
        logic              load;
        logic              step;
        logic              emit;
        logic              clear;
        logic              last;
        logic [ADDR_W-1:0] rd_addr;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic [CNT_W-1:0] row_count;
    } t_dp_sts;

endpackage

`default_nettype wire

[rtl/row_min_max_normalizer_core.sv]
// top level of the row min-max normaliser: controller plus datapath
// depends on rmmn_pkg, rmmn_ctrl and rmmn_dp
`default_nettype none

// Usage
//   Input: one row element per beat, taken at a clock edge with start high
//   and busy low. The beat whose row_end is set closes the row. Up to 64
//   elements are stored; further elements of the same row are dropped.
//   Elements without row_end leave busy low and give no result.
//   On row end the block raises busy and emits one result per stored
//   element, in order, each on o_result for exactly one cycle with
//   o_result_valid high; last_of_row marks the final one. The receiver
//   cannot stall, so nothing waits on it.
//   Sequence: the lowered minimum is formed first, then each element in
//   turn goes through buffer read, divider load, 15 divider steps and
//   emit; an element is read only after the previous one is emitted,
//   and busy stays high until the final element has been emitted.
//   Offset register: i_cfg_we with i_cfg_data writes min_offset at once;
//   write it only while busy is low.
//   Reset (synchronous, active low) clears the row, the offset and the
//   result strobe; the row buffer needs no clearing.
module row_min_max_normalizer_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire rmmn_pkg::t_in_item  i_item,
    input  wire logic                i_cfg_we,
    input  wire logic [14:0]         i_cfg_data,
    output logic                     o_result_valid,
    output rmmn_pkg::t_out_item      o_result
);

    rmmn_pkg::t_dp_cmd w_cmd;
    rmmn_pkg::t_dp_sts w_sts;

    // sequencing
    rmmn_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_row_end (i_item.row_end),
        .i_sts     (w_sts),
        .busy      (busy),
        .o_cmd     (w_cmd)
    );

    // storage and arithmetic
    rmmn_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_item         (i_item),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

`default_nettype wire

[rtl/rmmn_ctrl.sv]
// controller for the row min-max normaliser: walks the stored row,
// sequences the divider and issues datapath commands
// depends on rmmn_pkg
`default_nettype none

module rmmn_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire logic              i_row_end,
    input  wire rmmn_pkg::t_dp_sts i_sts,
    output logic                   busy,
    output rmmn_pkg::t_dp_cmd      o_cmd
);

    rmmn_pkg::t_state                    r_state, n_state;
    logic [rmmn_pkg::ADDR_W-1:0]         r_k, n_k;
    logic [rmmn_pkg::STEP_W-1:0]         r_step, n_step;
    logic                                w_last;

    // final element of the stored row
    assign w_last = ((rmmn_pkg::CNT_W'(r_k) + rmmn_pkg::CNT_W'(1)) == i_sts.row_count);

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rmmn_pkg::ST_IDLE;
            r_k     <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_step  <= n_step;
        end
    end

    // next state and commands
    always_comb begin
        n_state       = r_state;
        n_k           = r_k;
        n_step        = r_step;
        busy          = 1'b1;
        o_cmd         = '0;
        o_cmd.rd_addr = r_k;
        o_cmd.last    = w_last;
        unique case (r_state)
            rmmn_pkg::ST_IDLE: begin
                busy = 1'b0;
                n_k  = '0;
                if (start) begin
                    o_cmd.store = 1'b1;
                    if (i_row_end) begin
                        n_state = rmmn_pkg::ST_PREP;
                    end
                end
            end
            rmmn_pkg::ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = rmmn_pkg::ST_READ;
            end
            rmmn_pkg::ST_READ: begin
                n_state = rmmn_pkg::ST_LOAD;
            end
            rmmn_pkg::ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_step     = '0;
                n_state    = rmmn_pkg::ST_DIV;
            end
            rmmn_pkg::ST_DIV: begin
                o_cmd.step = 1'b1;
                n_step     = r_step + rmmn_pkg::STEP_W'(1);
                if (r_step == rmmn_pkg::STEP_W'(rmmn_pkg::DIV_STEPS - 1)) begin
                    n_state = rmmn_pkg::ST_EMIT;
                end
            end
            rmmn_pkg::ST_EMIT: begin
                o_cmd.emit = 1'b1;
                if (w_last) begin
                    o_cmd.clear = 1'b1;
                    n_state     = rmmn_pkg::ST_IDLE;
                end else begin
                    n_k     = r_k + rmmn_pkg::ADDR_W'(1);
                    n_state = rmmn_pkg::ST_READ;
                end
            end
            default: begin
                n_state = rmmn_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/rmmn_dp.sv]
// datapath for the row min-max normaliser: row buffer, running min and max,
// offset register, bit-serial restoring divider and result register
// depends on rmmn_pkg
`default_nettype none

module rmmn_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [14:0]        i_cfg_data,
    input  wire rmmn_pkg::t_in_item i_item,
    input  wire rmmn_pkg::t_dp_cmd  i_cmd,
    output rmmn_pkg::t_dp_sts       o_sts,
    output logic                    o_result_valid,
    output rmmn_pkg::t_out_item     o_result
);

    logic [15:0]                 r_mem [rmmn_pkg::MAX_ROW_LEN];
    logic [15:0]                 r_rd_data;
    logic [14:0]                 r_min_offset;
    logic signed [15:0]          r_min;
    logic signed [15:0]          r_max;
    logic [rmmn_pkg::CNT_W-1:0]  r_cnt;
    logic [17:0]                 r_low;
    logic [16:0]                 r_range;
    logic                        r_zr;
    logic [16:0]                 r_rem;
    logic [15:0]                 r_quo;
    logic                        r_out_vld;
    rmmn_pkg::t_out_item         r_out;

    logic                        w_room;
    logic                        w_wr;
    logic [17:0]                 n_low;
    logic [17:0]                 w_range18;
    logic [17:0]                 w_num18;
    logic [16:0]                 w_num;
    logic                        w_num_ge;
    logic [17:0]                 w_shift;
    logic                        w_step_ge;
    logic [17:0]                 w_step_sub;

    // buffer has room for another element
    assign w_room = (r_cnt < rmmn_pkg::CNT_W'(rmmn_pkg::MAX_ROW_LEN));
    assign w_wr   = i_cmd.store && w_room;

    // lowered minimum and range, 18-bit two's complement
    assign n_low     = {{2{r_min[15]}}, r_min} - {3'b000, r_min_offset};
    assign w_range18 = {{2{r_max[15]}}, r_max} - r_low;

    // numerator for the element being read, never above the range
    assign w_num18  = {{2{r_rd_data[15]}}, r_rd_data} - r_low;
    assign w_num    = w_num18[16:0];
    assign w_num_ge = (w_num >= w_range18[16:0]);

    // one restoring step
    assign w_shift    = {r_rem, 1'b0};
    assign w_step_ge  = (w_shift >= {1'b0, r_range});
    assign w_step_sub = w_shift - {1'b0, r_range};

    // row buffer write and registered read
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_cnt[rmmn_pkg::ADDR_W-1:0]] <= i_item.score_value;
        end
        r_rd_data <= r_mem[i_cmd.rd_addr];
    end

    // configuration and row statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_offset <= '0;
            r_min        <= 16'sh7FFF;
            r_max        <= 16'sh8000;
            r_cnt        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_min_offset <= i_cfg_data;
            end
            if (i_cmd.clear) begin
                r_min <= 16'sh7FFF;
                r_max <= 16'sh8000;
                r_cnt <= '0;
            end else if (w_wr) begin
                r_cnt <= r_cnt + rmmn_pkg::CNT_W'(1);
                if (i_item.score_value < r_min) begin
                    r_min <= i_item.score_value;
                end
                if (i_item.score_value > r_max) begin
                    r_max <= i_item.score_value;
                end
            end
        end
    end

    // lowered minimum, then range and zero flag
    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_low <= n_low;
        end
        if (i_cmd.load) begin
            r_range <= w_range18[16:0];
            r_zr    <= (w_range18[16:0] == 17'd0);
        end
    end

    // divider: integer bit on load, then one fraction bit per step
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem <= w_num_ge ? (w_num - w_range18[16:0]) : w_num;
            r_quo <= {15'd0, w_num_ge};
        end else if (i_cmd.step) begin
            r_rem <= w_step_ge ? w_step_sub[16:0] : w_shift[16:0];
            r_quo <= {r_quo[14:0], w_step_ge};
        end
    end

    // result register, strobed for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.scaled_value <= r_zr ? 16'd0 : r_quo;
            r_out.zero_range   <= r_zr;
            r_out.last_of_row  <= i_cmd.last;
        end
    end

    assign o_sts.row_count = r_cnt;
    assign o_result_valid  = r_out_vld;
    assign o_result        = r_out;

endmodule

`default_nettype wire

[tb/rmmn_result_checker.sv]
`timescale 1ns / 1ps
// result checker for the row min-max normaliser: keeps its own copy of the row,
// predicts each scaled beat and compares it with the block's result beats
// depends on rmmn_pkg
module rmmn_result_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic                i_busy,
    input  wire rmmn_pkg::t_in_item  i_item,
    input  wire logic                i_cfg_we,
    input  wire logic [14:0]         i_cfg_data,
    input  wire logic                i_result_valid,
    input  wire rmmn_pkg::t_out_item i_result,
    output int                       o_error_count,
    output int                       o_pending_count
);

    // shadow of the row buffer and running extremes
    logic signed [15:0]  row_buf [rmmn_pkg::MAX_ROW_LEN];
    logic signed [15:0]  row_lo;
    logic signed [15:0]  row_hi;
    int                  row_len;
    logic [14:0]         min_offset;
    rmmn_pkg::t_out_item scaled_q [$];
    int                  mismatch_total;

    initial begin
        mismatch_total  = 0;
        o_error_count   = 0;
        o_pending_count = 0;
        row_len         = 0;
        row_lo          = 16'sh7FFF;
        row_hi          = -16'sh7FFF - 16'sd1;
        min_offset      = '0;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatch_total++;
    endtask

    task automatic clear_row();
        row_lo  = 16'sh7FFF;
        row_hi  = -16'sh7FFF - 16'sd1;
        row_len = 0;
    endtask

    // store one element; on row end queue the scaled beats of the whole row
    task automatic take_element(input rmmn_pkg::t_in_item beat);
        int                  lo_i;
        int                  hi_i;
        int                  off_i;
        int                  lowered;
        int                  elem_i;
        longint              num_l;
        longint              span_l;
        longint              quot;
        rmmn_pkg::t_out_item want;
        if (row_len < rmmn_pkg::MAX_ROW_LEN) begin
            row_buf[row_len] = beat.score_value;
            row_len++;
            if (beat.score_value < row_lo) row_lo = beat.score_value;
            if (beat.score_value > row_hi) row_hi = beat.score_value;
        end
        if (!beat.row_end) return;
        lo_i    = row_lo;
        hi_i    = row_hi;
        off_i   = min_offset;
        lowered = lo_i - off_i;
        span_l  = hi_i - lowered;
        for (int k = 0; k < row_len; k++) begin
            elem_i = row_buf[k];
            num_l  = elem_i - lowered;
            if (span_l == 0) begin
                want.scaled_value = '0;
                want.zero_range   = 1'b1;
            end else begin
                quot = (num_l << 15) / span_l;
                if (quot > 32768) quot = 32768;
                want.scaled_value = quot[15:0];
                want.zero_range   = 1'b0;
            end
            want.last_of_row = (k == row_len - 1);
            scaled_q.push_back(want);
        end
        clear_row();
    endtask

    // compare one result beat with the oldest prediction
    task automatic check_result(input rmmn_pkg::t_out_item got);
        rmmn_pkg::t_out_item want;
        if (scaled_q.size() == 0) begin
            report_mismatch($sformatf("result beat with none pending: value %0d zr %0b last %0b",
                                      got.scaled_value, got.zero_range, got.last_of_row));
        end else begin
            want = scaled_q.pop_front();
            if (got.scaled_value !== want.scaled_value)
                report_mismatch($sformatf("scaled_value got %0d want %0d",
                                          got.scaled_value, want.scaled_value));
            if (got.zero_range !== want.zero_range)
                report_mismatch($sformatf("zero_range got %0b want %0b",
                                          got.zero_range, want.zero_range));
            if (got.last_of_row !== want.last_of_row)
                report_mismatch($sformatf("last_of_row got %0b want %0b",
                                          got.last_of_row, want.last_of_row));
        end
    endtask

    // watch the channels at each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_row();
            min_offset = '0;
            scaled_q.delete();
        end else begin
            if (i_result_valid) check_result(i_result);
            if (i_cfg_we) min_offset = i_cfg_data;
            if (i_start && !i_busy) take_element(i_item);
        end
        o_error_count   <= mismatch_total;
        o_pending_count <= scaled_q.size();
    end

endmodule

[tb/row_min_max_normalizer_core_test.sv]
`timescale 1ns / 1ps
// top of the row min-max normaliser testbench: clock, reset, row stimulus,
// offset writes, watchdog and verdict; depends on rmmn_pkg, the core and
// rmmn_result_checker
module row_min_max_normalizer_core_test;

    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 2000;
    localparam int HALF_BEATS    = 15;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                start          = 1'b0;
    logic                busy;
    rmmn_pkg::t_in_item  i_item         = '0;
    logic                i_cfg_we       = 1'b0;
    logic [14:0]         i_cfg_data     = '0;
    logic                o_result_valid;
    rmmn_pkg::t_out_item o_result;

    int error_count;
    int pending_count;
    int stall_cycles    = 0;
    int beats_sent      = 0;
    int sender_idle_pct = 0;
    int beat_goal;
    int row_len_pick;

    row_min_max_normalizer_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    rmmn_result_checker u_result_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_item          (i_item),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_result_valid  (o_result_valid),
        .i_result        (o_result),
        .o_error_count   (error_count),
        .o_pending_count (pending_count)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog on cycles with no beat moving either way
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // one input beat, with random idle cycles ahead of it
    task automatic send_beat(input logic signed [15:0] value, input logic last);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= {value, last};
        do @(posedge i_clk); while (busy);
        beats_sent++;
    endtask

    task automatic send_flat_row(input logic signed [15:0] value, input int len);
        for (int k = 0; k < len; k++) send_beat(value, k == len - 1);
    endtask

    // random row: wide spread, narrow band or all equal
    task automatic send_random_row(input int len);
        int                 kind;
        logic signed [15:0] base;
        logic signed [15:0] value;
        kind = $urandom_range(9);
        base = 16'($urandom);
        for (int k = 0; k < len; k++) begin
            if (kind < 4) value = 16'($urandom);
            else if (kind < 8) value = base + 16'($urandom_range(0, 255));
            else value = base;
            send_beat(value, k == len - 1);
        end
    endtask

    // mostly short rows, now and then a full or overlong one
    function automatic int pick_row_len();
        int r;
        r = $urandom_range(99);
        if (r < 75) return $urandom_range(1, 6);
        else if (r < 92) return $urandom_range(7, 20);
        else if (r < 98) return $urandom_range(21, 64);
        else return $urandom_range(65, 70);
    endfunction

    // hold the sender until every pending result has come and the core settles
    task automatic drain_results();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending_count != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_offset(input logic [14:0] value);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows: extremes, single elements, zero range
        sender_idle_pct = 30;
        set_offset(15'd0);
        send_flat_row(16'h8000, 1);
        send_flat_row(16'h7FFF, 1);
        send_beat(16'h7FFF, 1'b0);
        send_beat(16'h8000, 1'b0);
        send_beat(16'h0000, 1'b1);
        send_flat_row(16'sd5, 4);
        send_beat(-16'sd1, 1'b0);
        send_beat(16'sd0, 1'b0);
        send_beat(16'sd1, 1'b0);
        send_beat(16'sd4096, 1'b0);
        send_beat(-16'sd4096, 1'b1);
        set_offset(15'h7FFF);
        send_flat_row(16'h8000, 1);
        send_beat(16'h7FFF, 1'b0);
        send_beat(16'h8000, 1'b1);
        send_flat_row(16'sd7, 2);

        // random rows over three idle settings, two offsets each
        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 85 : 0;
            for (int half = 0; half < 2; half++) begin
                case (phase * 2 + half)
                    0:       set_offset(15'($urandom_range(1, 32766)));
                    1:       set_offset(15'd0);
                    2:       set_offset(15'($urandom_range(1, 64)));
                    3:       set_offset(15'h7FFF);
                    4:       set_offset(15'd0);
                    default: set_offset(15'($urandom_range(0, 32767)));
                endcase
                beat_goal = beats_sent + HALF_BEATS;
                // row end landing on a full buffer
                if (phase == 0 && half == 0) send_random_row(rmmn_pkg::MAX_ROW_LEN + 1);
                while (beats_sent < beat_goal) begin
                    row_len_pick = pick_row_len();
                    if (row_len_pick > beat_goal - beats_sent)
                        row_len_pick = beat_goal - beats_sent;
                    send_random_row(row_len_pick);
                end
            end
        end

        drain_results();
        if (error_count == 0 && pending_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/rmmn_pkg.sv
rtl/rmmn_ctrl.sv
rtl/rmmn_dp.sv
rtl/row_min_max_normalizer_core.sv
tb/rmmn_result_checker.sv
tb/row_min_max_normalizer_core_test.sv
